/* rtl/lpht_pkg.sv */
`timescale 1ns / 1ps

package lpht_pkg;

  localparam int SlotsDefault    = 26;
  localparam int KeyBytesDefault = 8;

  localparam int KeyW   = 64;
  localparam int PhoneW = 34;
  localparam int IndexW = 5;

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;
  localparam logic [7:0] CaseOffset = 8'h20;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_DELETE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_KEY   = 2'd3
  } status_t;

  typedef struct packed {
    func_t              func;
    logic [KeyW-1:0]    name_key;
    logic [PhoneW-1:0]  phone_number;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic [IndexW-1:0]  slot_index;
  } rsp_t;

  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [PhoneW-1:0]  phone;
  } entry_t;

endpackage

/* rtl/lpht_ram.sv */
`timescale 1ns / 1ps

module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/linear_probe_hash_table.sv */
`timescale 1ns / 1ps

// Contact table with linear probing. One word goes in on cmd, one word comes back on rsp.
// An insert takes the upper-cased first character of the key as its home slot and walks the
// slot-used flags one slot per cycle, wrapping, until it finds a free slot or has probed all
// slots (table full). A delete walks the key memory from slot 0, one read per cycle with the
// compare in the cycle after the read. A key whose first character is not a letter goes
// straight to a bad-key response. The slot-used flags sit in flip-flops cleared by reset, so
// the block needs no clearing pass and takes commands right after reset. A finished response
// waits in an output register, so the next command can be accepted and worked on while the
// previous response is still held.
module linear_probe_hash_table
  import lpht_pkg::*;
#(
  parameter int SLOTS     = SlotsDefault,
  parameter int KEY_BYTES = KeyBytesDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int SlotW = $clog2(SLOTS);
  localparam logic [KeyW-1:0] KeyMask = {KeyW{1'b1}} << (8 * (8 - KEY_BYTES));
  localparam logic [SlotW-1:0] LastSlot = SlotW'(SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t            state;
  logic [SLOTS-1:0]  used;
  logic [KeyW-1:0]   key;
  logic [PhoneW-1:0] phone;
  logic [SlotW-1:0]  idx;
  logic [SlotW-1:0]  probe_cnt;
  logic              chk_valid;
  logic [SlotW-1:0]  chk_idx;
  status_t           res_status;
  logic [SlotW-1:0]  res_slot;

  logic [7:0]        first_ch;
  logic [7:0]        upper_ch;
  logic              is_letter;
  logic [SlotW-1:0]  home;
  logic [KeyW-1:0]   in_key;
  logic              mem_we;
  entry_t            wr_entry;
  entry_t            rd_entry;
  logic              key_hit;
  logic              out_free;

  assign in_key   = cmd.name_key & KeyMask;
  assign first_ch = in_key[KeyW-1 -: 8];
  assign upper_ch = (first_ch >= CharLowerA && first_ch <= CharLowerZ) ?
                    first_ch - CaseOffset : first_ch;
  assign is_letter = (upper_ch >= CharUpperA) && (upper_ch <= CharUpperZ);
  // Letters give 0..25, which is below SLOTS only when SLOTS is 26 or more; no wrap is applied here.
  assign home = SlotW'(upper_ch - CharUpperA);

  assign mem_we   = (state == S_PROBE) && !used[idx];
  assign wr_entry = '{key: key, phone: phone};

  // The key read issued at idx returns in the next cycle, tagged by chk_idx.
  assign key_hit  = chk_valid && used[chk_idx] && (rd_entry.key == key);
  assign out_free = !rsp_valid || rsp_ready;

  assign cmd_ready = (state == S_IDLE);

  lpht_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx),
    .wdata (wr_entry),
    .raddr (idx),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      chk_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // In S_FINISH the response register is reloaded below instead.
      if (rsp_valid && rsp_ready && state != S_FINISH) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            key       <= in_key;
            phone     <= cmd.phone_number;
            probe_cnt <= '0;
            chk_valid <= 1'b0;
            if (!is_letter) begin
              res_status <= ST_BAD_KEY;
              res_slot   <= '0;
              state      <= S_FINISH;
            end else if (cmd.func == FUNC_INSERT) begin
              idx   <= home;
              state <= S_PROBE;
            end else begin
              idx   <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_PROBE: begin
          if (!used[idx]) begin
            used[idx]  <= 1'b1;
            res_status <= ST_OK;
            res_slot   <= idx;
            state      <= S_FINISH;
          end else if (probe_cnt == LastSlot) begin
            res_status <= ST_FULL;
            res_slot   <= '0;
            state      <= S_FINISH;
          end else begin
            idx       <= (idx == LastSlot) ? '0 : idx + 1'b1;
            probe_cnt <= probe_cnt + 1'b1;
          end
        end
        S_SCAN: begin
          chk_valid <= 1'b1;
          chk_idx   <= idx;
          if (idx != LastSlot) begin
            idx <= idx + 1'b1;
          end
          if (key_hit) begin
            used[chk_idx] <= 1'b0;
            res_status    <= ST_OK;
            res_slot      <= chk_idx;
            state         <= S_FINISH;
          end else if (chk_valid && chk_idx == LastSlot) begin
            res_status <= ST_NOT_FOUND;
            res_slot   <= '0;
            state      <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            rsp_valid      <= 1'b1;
            rsp.status     <= res_status;
            rsp.slot_index <= IndexW'(res_slot);
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/lpht_checker.sv */
`timescale 1ns / 1ps

module lpht_checker
  import lpht_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input cmd_t cmd,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  logic [1:0] pending;
  logic       cmd_fire;
  logic       rsp_fire;

  assign cmd_fire = cmd_valid && cmd_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  // Words accepted on cmd whose response has not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, cmd_fire} - {1'b0, rsp_fire};
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response word changed or dropped while stalled");

  a_no_spurious_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("response word without an accepted command");

  a_bounded_pending: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two commands outstanding");

  a_idx_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.slot_index == '0)
    else $error("slot index not zero on a failed operation");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd       (cmd),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

/* test/tb_linear_probe_hash_table.sv */
`timescale 1ns / 1ps

module tb_linear_probe_hash_table;
  import lpht_pkg::*;

  localparam int SLOTS      = SlotsDefault;
  localparam int KEY_BYTES  = KeyBytesDefault;
  localparam logic [KeyW-1:0] KEY_MASK = {KeyW{1'b1}} << (8 * (8 - KEY_BYTES));
  localparam int RANDOM_WORDS = 1100;
  localparam int KEY_POOL     = 48;
  localparam int HOLD_AT      = 250;
  localparam int HOLD_CYCLES  = 300;
  localparam int PAUSE_AT     = 550;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    cmd_t word;
    bit   typed;
    rsp_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Side channel that travels with each command word to the checker.
  bit   word_typed = 1'b0;
  rsp_t word_want = '0;

  bit              tbl_used [SLOTS];
  logic [KeyW-1:0] tbl_key  [SLOTS];

  rsp_t            pending_rsp [$];
  row_t            plan [$];
  logic [KeyW-1:0] key_pool [KEY_POOL];

  int error_count = 0;
  int rsp_count = 0;
  int status_seen [4];
  int long_hold_left = 0;
  int stall_left = 0;
  bit hold_done = 1'b0;

  linear_probe_hash_table #(
    .SLOTS(SLOTS),
    .KEY_BYTES(KEY_BYTES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one command to the local copy of the table and returns its response.
  function automatic rsp_t apply_command(input cmd_t c);
    rsp_t r;
    logic [7:0] first;
    logic [KeyW-1:0] k;
    int home;
    int s;
    r.status = ST_OK;
    r.slot_index = '0;
    k = c.name_key & KEY_MASK;
    first = k[KeyW-1 -: 8];
    if (first >= CharLowerA && first <= CharLowerZ) first = first - CaseOffset;
    if (first < CharUpperA || first > CharUpperZ) begin
      r.status = ST_BAD_KEY;
      return r;
    end
    home = (first - CharUpperA) % SLOTS;
    if (c.func == FUNC_INSERT) begin
      for (int i = 0; i < SLOTS; i++) begin
        s = (home + i) % SLOTS;
        if (!tbl_used[s]) begin
          tbl_used[s] = 1'b1;
          tbl_key[s] = k;
          r.slot_index = s[IndexW-1:0];
          return r;
        end
      end
      r.status = ST_FULL;
      return r;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_used[i] && tbl_key[i] == k) begin
        tbl_used[i] = 1'b0;
        tbl_key[i] = '0;
        r.slot_index = i[IndexW-1:0];
        return r;
      end
    end
    r.status = ST_NOT_FOUND;
    return r;
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic note_error(input string msg);
    if (error_count < 10) $display("ERROR: %s", msg);
    error_count++;
  endtask

  task automatic add_row(input func_t f, input logic [KeyW-1:0] k, input logic [PhoneW-1:0] p,
                         input bit typed, input status_t st, input logic [IndexW-1:0] idx);
    row_t row;
    row.word.func = f;
    row.word.name_key = k;
    row.word.phone_number = p;
    row.typed = typed;
    row.want.status = st;
    row.want.slot_index = idx;
    plan.push_back(row);
  endtask

  // Called at a rising edge; returns at the edge where the word is accepted.
  task automatic send_word(input cmd_t c, input bit typed, input rsp_t want, input int gap);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    word_typed <= typed;
    word_want <= want;
    do @(posedge clk); while (!cmd_ready);
  endtask

  function automatic logic [KeyW-1:0] random_key(input bit for_delete);
    logic [KeyW-1:0] k;
    if ($urandom_range(0, 99) < (for_delete ? 10 : 8)) begin
      k = {$urandom, $urandom};
    end else begin
      k = key_pool[$urandom_range(0, KEY_POOL - 1)];
    end
    return k;
  endfunction

  always @(posedge clk) begin : check_p
    rsp_t want;
    rsp_t pred;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (pending_rsp.size() == 0) begin
          note_error($sformatf("response %s slot %0d with nothing expected",
                               rsp.status.name(), rsp.slot_index));
        end else begin
          want = pending_rsp.pop_front();
          status_seen[want.status]++;
          if (rsp.status !== want.status || rsp.slot_index !== want.slot_index) begin
            note_error($sformatf("response %0d: status %s slot %0d, expected %s slot %0d",
                                 rsp_count, rsp.status.name(), rsp.slot_index,
                                 want.status.name(), want.slot_index));
          end
        end
        rsp_count <= rsp_count + 1;
      end
      if (cmd_valid && cmd_ready) begin
        pred = apply_command(cmd);
        pending_rsp.push_back(word_typed ? word_want : pred);
      end
    end
  end

  // Receiver: random stalls, quiet stretches, and one long hold-off so the input backs up.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (!hold_done && rsp_count >= HOLD_AT) begin
      rsp_ready <= 1'b0;
      long_hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else if (long_hold_left > 0) begin
      rsp_ready <= 1'b0;
      long_hold_left <= long_hold_left - 1;
    end else if (stall_left > 0) begin
      rsp_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp_ready <= 1'b1;
      if ((rsp_count / 100) % 4 != 1 && $urandom_range(0, 99) < 20) stall_left <= idle_gap();
    end
  end

  initial begin
    cmd_t c;
    rsp_t none;
    int ins_pct;
    int bias [4];
    int gap;
    logic [7:0] first;
    none = '0;
    bias = '{80, 97, 50, 15};
    for (int i = 0; i < KEY_POOL; i++) begin
      first = ($urandom_range(0, 99) < 70) ? CharUpperA + 8'($urandom_range(0, 25))
                                           : CharLowerA + 8'($urandom_range(0, 25));
      key_pool[i] = {first, 24'($urandom), $urandom};
    end

    add_row(FUNC_INSERT, 64'h414C_4943_4500_0000, 34'd0, 1, ST_OK, 5'd0);
    add_row(FUNC_INSERT, 64'h5AFF_FFFF_FFFF_FFFF, 34'h3_FFFF_FFFF, 1, ST_OK, 5'd25);
    add_row(FUNC_INSERT, 64'h7A6F_6500_0000_0000, 34'd9999999999, 0, ST_OK, 5'd0);
    add_row(FUNC_INSERT, 64'h4000_0000_0000_0000, 34'd1, 1, ST_BAD_KEY, 5'd0);
    add_row(FUNC_INSERT, 64'h5B41_4200_0000_0000, 34'd2, 1, ST_BAD_KEY, 5'd0);
    add_row(FUNC_DELETE, 64'h6000_0000_0000_0000, 34'd3, 1, ST_BAD_KEY, 5'd0);
    add_row(FUNC_DELETE, 64'h7B00_0000_0000_0000, 34'd4, 1, ST_BAD_KEY, 5'd0);
    add_row(FUNC_INSERT, 64'h0000_0000_0000_0000, 34'd5, 1, ST_BAD_KEY, 5'd0);
    add_row(FUNC_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 34'h3_FFFF_FFFF, 1, ST_BAD_KEY, 5'd0);
    add_row(FUNC_INSERT, 64'hE100_0000_0000_0000, 34'd6, 1, ST_BAD_KEY, 5'd0);
    add_row(FUNC_DELETE, 64'h424F_4200_0000_0000, 34'd7, 1, ST_NOT_FOUND, 5'd0);
    // A second ALICE is a duplicate and lands past the occupied slots.
    add_row(FUNC_INSERT, 64'h414C_4943_4500_0000, 34'h1_5555_5555, 0, ST_OK, 5'd0);
    add_row(FUNC_DELETE, 64'h414C_4943_4500_0000, 34'd0, 0, ST_OK, 5'd0);
    add_row(FUNC_DELETE, 64'h616C_6963_6500_0000, 34'd0, 0, ST_OK, 5'd0);
    add_row(FUNC_DELETE, 64'h414C_4943_4500_0000, 34'd0, 0, ST_OK, 5'd0);
    add_row(FUNC_DELETE, 64'h414C_4943_4500_0000, 34'd0, 0, ST_OK, 5'd0);
    add_row(FUNC_INSERT, 64'h6D69_6B65_0000_0000, 34'h2_AAAA_AAAA, 0, ST_OK, 5'd0);
    add_row(FUNC_DELETE, 64'h7A6F_6500_0000_0000, 34'd0, 0, ST_OK, 5'd0);
    add_row(FUNC_DELETE, 64'h5AFF_FFFF_FFFF_FFFF, 34'd0, 0, ST_OK, 5'd0);
    add_row(FUNC_DELETE, 64'h6D69_6B65_0000_0000, 34'h1_2345_6789, 0, ST_OK, 5'd0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      send_word(plan[i].word, plan[i].typed, plan[i].want, idle_gap());
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      ins_pct = bias[(n / 50) % 4];
      c.func = ($urandom_range(0, 99) < ins_pct) ? FUNC_INSERT : FUNC_DELETE;
      c.name_key = random_key(c.func == FUNC_DELETE);
      c.phone_number = {2'($urandom_range(0, 3)), 32'($urandom)};
      gap = ((n / 100) % 5 == 3) ? 0 : idle_gap();
      if (n == PAUSE_AT) begin
        // Let the block drain completely before carrying on.
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0) @(posedge clk);
        gap = 0;
      end
      send_word(c, 1'b0, none, gap);
    end
    cmd_valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_rsp.size() != 0) note_error("expected responses left over at the end");
    if (error_count > 10) $display("%0d mismatches in total", error_count);
    $display("Ran %0d commands: %0d ok, %0d table full, %0d key not found, %0d bad key.",
             rsp_count, status_seen[ST_OK], status_seen[ST_FULL],
             status_seen[ST_NOT_FOUND], status_seen[ST_BAD_KEY]);
    $display("Included a %0d-cycle output hold-off and one full drain mid-run.", HOLD_CYCLES);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d responses still expected.", pending_rsp.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/linear_probe_hash_table.sv
rtl/lpht_checker.sv
test/tb_linear_probe_hash_table.sv
